// ===== src/eos_pkg.sv =====
// Shared types and constants for the elevator order scheduler.
package eos_pkg;

  localparam int FLOORS   = 4;
  localparam int KINDS    = 3;
  localparam int IDX_W    = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int TBL_BITS = FLOORS * KINDS;
  localparam int BTN_W    = 12;
  localparam int SENSOR_W = 3;
  localparam int FLOOR_W  = 4;

  // order flag positions within one floor
  localparam int K_UP  = 0;
  localparam int K_DN  = 1;
  localparam int K_CAB = 2;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_POLL      = 3'd1,
    CMD_LATCH     = 3'd2,
    CMD_CLR_FLOOR = 3'd3,
    CMD_CLR_ALL   = 3'd4,
    CMD_TURN      = 3'd5
  } cmd_t;

  typedef logic [1:0] stop_t;
  localparam stop_t STOP_NONE = 2'd0;
  localparam stop_t STOP_HERE = 2'd1;
  localparam stop_t STOP_PASS = 2'd2;

  typedef logic [FLOORS-1:0][KINDS-1:0] flags_t;

  // control from the command decode to the order table
  typedef struct packed {
    logic                wipe;
    logic                latch;
    logic                clear_one;
    logic [IDX_W-1:0]    idx;
    logic [TBL_BITS-1:0] buttons;
  } tbl_ctrl_t;

endpackage

// ===== src/eos_order_table.sv =====
// Per-floor order flags: latch, clear one floor, clear all.
module eos_order_table
  import eos_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      commit,
  input  tbl_ctrl_t ctrl,
  output flags_t    flags,
  output logic      pending_next
);

  flags_t flags_next;

  always_comb begin
    flags_next = flags;
    if (ctrl.wipe) begin
      flags_next = '0;
    end else if (ctrl.clear_one) begin
      flags_next[ctrl.idx] = '0;
    end else if (ctrl.latch) begin
      for (int f = 0; f < FLOORS; f++) begin
        for (int k = 0; k < KINDS; k++) begin
          // no down call at the bottom, no up call at the top
          if (!((f == 0) && (k == K_DN)) && !((f == FLOORS - 1) && (k == K_UP))) begin
            flags_next[f][k] = flags[f][k] | ctrl.buttons[f*KINDS + k];
          end
        end
      end
    end
  end

  assign pending_next = |flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (commit) begin
      flags <= flags_next;
    end
  end

endmodule

// ===== src/eos_scan_decide.sv =====
// SCAN look-ahead over the floors and the stop/pass decision of a poll.
module eos_scan_decide
  import eos_pkg::*;
(
  input  flags_t                    flags,
  input  logic signed [FLOOR_W-1:0] from_floor,
  input  logic                      down,
  input  logic                      poll_hit,
  input  logic [IDX_W-1:0]          here_idx,
  output logic                      ahead,
  output stop_t                     stop
);

  logic [KINDS-1:0] here;
  logic             call_hit;

  always_comb begin
    ahead = 1'b0;
    for (int f = 0; f < FLOORS; f++) begin
      if ((down ? (f < int'(from_floor)) : (f > int'(from_floor))) && (|flags[f])) begin
        ahead = 1'b1;
      end
    end
  end

  assign here     = flags[here_idx];
  assign call_hit = here[K_CAB] | (!down & here[K_UP]) | (down & here[K_DN]);

  always_comb begin
    if (!poll_hit) begin
      stop = STOP_NONE;
    end else if (call_hit || !ahead) begin
      stop = STOP_HERE;
    end else begin
      stop = STOP_PASS;
    end
  end

endmodule

// ===== src/elevator_order_scheduler_core.sv =====
// Top level: elevator order table with SCAN direction control.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  request | cmd_valid | cmd_stall | command, floor_sensor, button_bits
//  result  | res_valid | res_stall | stop_code, orders_pending, going_down,
//          |           |           | floor_now
//
// One request per cycle sustained while the result is not stalled. The command
// executes from the input register, and its result is loaded into the output
// register when that register is free or draining.
// Reset clears the order flags, sets direction up and floor to -1 (unknown).
// A stalled result holds the output register; the input register still takes
// one more request, and cmd_stall rises only when both registers are full.
// The block state (flags, direction, floor) updates only when a request
// moves into the output register, so requests execute strictly in order.
module elevator_order_scheduler_core
  import eos_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [2:0]                 command,
  input  logic signed [SENSOR_W-1:0] floor_sensor,
  input  logic [BTN_W-1:0]           button_bits,

  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [1:0]                 stop_code,
  output logic                       orders_pending,
  output logic                       going_down,
  output logic signed [FLOOR_W-1:0]  floor_now
);

  // input register
  logic                       s1_valid;
  logic [2:0]                 s1_cmd;
  logic signed [SENSOR_W-1:0] s1_sensor;
  logic [BTN_W-1:0]           s1_buttons;

  // architectural state
  logic                      travel_down;
  logic                      travel_down_next;
  logic signed [FLOOR_W-1:0] floor_reg;
  logic signed [FLOOR_W-1:0] floor_reg_next;

  logic advance;
  logic commit;

  // Output register free or draining this cycle.
  assign advance   = !res_valid || !res_stall;
  assign commit    = s1_valid && advance;
  assign cmd_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_cmd     <= command;
      s1_sensor  <= floor_sensor;
      s1_buttons <= button_bits;
    end
  end

  // ---- decode -------------------------------------------------------------
  logic signed [FLOOR_W-1:0] sensor_ext;
  logic                      sensor_ok;
  logic                      floor_ok;
  logic                      is_poll;
  logic                      poll_hit;
  logic signed [FLOOR_W-1:0] from_floor;
  tbl_ctrl_t                 tbl_ctrl;
  flags_t                    flags;
  logic                      pending_next;
  logic                      ahead;
  stop_t                     stop;

  assign sensor_ext = {s1_sensor[SENSOR_W-1], s1_sensor};
  assign sensor_ok  = !s1_sensor[SENSOR_W-1] && (int'(s1_sensor) < FLOORS);
  assign floor_ok   = !floor_reg[FLOOR_W-1] && (int'(floor_reg) < FLOORS);
  assign is_poll    = (s1_cmd == CMD_POLL);
  assign poll_hit   = is_poll && sensor_ok;

  // A poll looks ahead from the floor it is about to record.
  assign from_floor = is_poll ? sensor_ext : floor_reg;

  always_comb begin
    tbl_ctrl           = '0;
    tbl_ctrl.idx       = IDX_W'($unsigned(floor_reg));
    tbl_ctrl.buttons   = TBL_BITS'(s1_buttons);
    unique case (s1_cmd)
      CMD_INIT:      tbl_ctrl.wipe      = 1'b1;
      CMD_CLR_ALL:   tbl_ctrl.wipe      = 1'b1;
      CMD_LATCH:     tbl_ctrl.latch     = 1'b1;
      CMD_CLR_FLOOR: tbl_ctrl.clear_one = floor_ok;
      default:       tbl_ctrl.wipe      = 1'b0;
    endcase
  end

  eos_order_table u_table (
    .clk          (clk),
    .rst          (rst),
    .commit       (commit),
    .ctrl         (tbl_ctrl),
    .flags        (flags),
    .pending_next (pending_next)
  );

  eos_scan_decide u_decide (
    .flags      (flags),
    .from_floor (from_floor),
    .down       (travel_down),
    .poll_hit   (poll_hit),
    .here_idx   (IDX_W'($unsigned(s1_sensor))),
    .ahead      (ahead),
    .stop       (stop)
  );

  // ---- direction and floor ------------------------------------------------
  always_comb begin
    travel_down_next = travel_down;
    floor_reg_next   = floor_reg;
    unique case (s1_cmd)
      CMD_INIT: begin
        travel_down_next = 1'b0;
        floor_reg_next   = sensor_ext;
      end
      CMD_POLL: begin
        if (sensor_ok) begin
          floor_reg_next = sensor_ext;
        end
      end
      CMD_TURN: begin
        // nothing ahead: reverse, and step one floor on along the old direction
        if (!ahead) begin
          travel_down_next = !travel_down;
          floor_reg_next   = travel_down ? floor_reg - FLOOR_W'(1)
                                         : floor_reg + FLOOR_W'(1);
        end
      end
      default: begin
        travel_down_next = travel_down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_down <= 1'b0;
      floor_reg   <= -FLOOR_W'(1);
    end else if (commit) begin
      travel_down <= travel_down_next;
      floor_reg   <= floor_reg_next;
    end
  end

  // ---- output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      stop_code      <= stop;
      orders_pending <= pending_next;
      going_down     <= travel_down_next;
      floor_now      <= floor_reg_next;
    end
  end

endmodule
